FILE: sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, arithmetic constants, sector codes and inter-stage types.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths on the stream ports.
  localparam int HUE_W    = 9;
  localparam int PCT_W    = 7;
  localparam int CH_W     = 8;
  localparam int TDATA_W  = 24;

  // Internal datapath widths, sized for clamped percentages.
  localparam int DIST_W       = 6;   // distance from hue 60, 180 or 300, 0..60
  localparam int BASE_W       = 15;  // v*255 up to 25500
  localparam int K_W          = 13;  // s*(60-d) + (100-s)*60 up to 6000
  localparam int SMALL_PROD_W = 22;  // base*(100-s) up to 2550000
  localparam int MID_PROD_W   = 28;  // base*k up to 153000000

  // Arithmetic constants.
  localparam int FULL_PCT   = 100;
  localparam int SECTOR_DEG = 60;
  localparam int HUE_LIMIT  = 360;
  localparam int DIV_BIG    = 100;
  localparam int DIV_SMALL  = 10000;
  localparam int DIV_MID    = 600000;

  // Sixty-degree hue sectors, named after the colors at their edges.
  typedef enum logic [2:0] {
    SECT_RED_YELLOW    = 3'd0,
    SECT_YELLOW_GREEN  = 3'd1,
    SECT_GREEN_CYAN    = 3'd2,
    SECT_CYAN_BLUE     = 3'd3,
    SECT_BLUE_MAGENTA  = 3'd4,
    SECT_MAGENTA_RED   = 3'd5
  } sector_e;

  // Front end result handed to the multiply and divide back end.
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [PCT_W-1:0]  comp_sat;
    logic [K_W-1:0]    k;
    sector_e           sector;
    logic              black;
  } front_t;

  // Stage control handed to each constant divider.
  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

endpackage

FILE: sv/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Two pipeline stages: clamping and sector decode, then the v*255 base and
// the weight k that sets the middle channel.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] saturation_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] brightness_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsv2rgb_pkg::front_t   out_o
);

  localparam int HW = hsv2rgb_pkg::HUE_W;
  localparam int PW = hsv2rgb_pkg::PCT_W;
  localparam int DW = hsv2rgb_pkg::DIST_W;
  localparam int BW = hsv2rgb_pkg::BASE_W;
  localparam int KW = hsv2rgb_pkg::K_W;
  localparam int DEG = hsv2rgb_pkg::SECTOR_DEG;

  localparam logic [HW-1:0] HUE_60  = HW'(DEG);
  localparam logic [HW-1:0] HUE_120 = HW'(2 * DEG);
  localparam logic [HW-1:0] HUE_180 = HW'(3 * DEG);
  localparam logic [HW-1:0] HUE_240 = HW'(4 * DEG);
  localparam logic [HW-1:0] HUE_300 = HW'(5 * DEG);
  localparam logic [HW-1:0] HUE_END = HW'(hsv2rgb_pkg::HUE_LIMIT);
  localparam logic [PW-1:0] PCT_MAX = PW'(hsv2rgb_pkg::FULL_PCT);

  // Stage handshake: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q;
  logic en1, en2;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign out_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage 1: clamp percentages, find the sector and the distance d from hue 60, 180 or 300.
  logic [PW-1:0]        sat_d, val_d;
  logic [HW-1:0]        hue_mod;
  logic [HW-1:0]        dist_wide;
  hsv2rgb_pkg::sector_e sector_d;
  logic                 black_d;

  always_comb begin
    sat_d   = (saturation_i > PCT_MAX) ? PCT_MAX : saturation_i;
    val_d   = (brightness_i > PCT_MAX) ? PCT_MAX : brightness_i;
    black_d = (hue_i >= HUE_END);

    if (hue_i >= HUE_240) begin
      hue_mod = hue_i - HUE_240;
    end else if (hue_i >= HUE_120) begin
      hue_mod = hue_i - HUE_120;
    end else begin
      hue_mod = hue_i;
    end
    dist_wide = (hue_mod >= HUE_60) ? (hue_mod - HUE_60) : (HUE_60 - hue_mod);

    if (hue_i < HUE_60) begin
      sector_d = hsv2rgb_pkg::SECT_RED_YELLOW;
    end else if (hue_i < HUE_120) begin
      sector_d = hsv2rgb_pkg::SECT_YELLOW_GREEN;
    end else if (hue_i < HUE_180) begin
      sector_d = hsv2rgb_pkg::SECT_GREEN_CYAN;
    end else if (hue_i < HUE_240) begin
      sector_d = hsv2rgb_pkg::SECT_CYAN_BLUE;
    end else if (hue_i < HUE_300) begin
      sector_d = hsv2rgb_pkg::SECT_BLUE_MAGENTA;
    end else begin
      sector_d = hsv2rgb_pkg::SECT_MAGENTA_RED;
    end
  end

  logic [PW-1:0]        sat_q, val_q;
  logic [DW-1:0]        dist_q;
  hsv2rgb_pkg::sector_e sector1_q;
  logic                 black1_q;

  // A hue out of range takes distance zero so every level stays within 8 bits.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      sat_q     <= sat_d;
      val_q     <= val_d;
      dist_q    <= black_d ? '0 : dist_wide[DW-1:0];
      sector1_q <= sector_d;
      black1_q  <= black_d;
    end
  end

  // Stage 2: base = v*255 by shift and subtract, and k = s*(60-d) + (100-s)*60.
  logic [BW-1:0] base_d;
  logic [PW-1:0] comp_sat_d;
  logic [DW-1:0] rise;
  logic [KW-1:0] k_d;

  always_comb begin
    base_d     = {val_q, 8'b0} - BW'(val_q);
    comp_sat_d = PCT_MAX - sat_q;
    rise       = DW'(DEG) - dist_q;
    k_d        = KW'(sat_q) * KW'(rise) + KW'(comp_sat_d) * KW'(DEG);
  end

  hsv2rgb_pkg::front_t out_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      out_q.base     <= base_d;
      out_q.comp_sat <= comp_sat_d;
      out_q.k        <= k_d;
      out_q.sector   <= sector1_q;
      out_q.black    <= black1_q;
    end
  end

  assign out_o = out_q;

endmodule

FILE: sv/hsv2rgb_cdiv.sv
// ----------------------------------------------------------------------------
// Constant divider
// Registers a reciprocal estimate of x / DIVISOR and corrects it by one
// compare and subtract on the way out.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv #(
  parameter int XW      = hsv2rgb_pkg::MID_PROD_W,
  parameter int DIVISOR = hsv2rgb_pkg::DIV_MID
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsv2rgb_pkg::stage_ctl_t       ctl_i,
  input  logic [XW-1:0]                 x_i,
  output logic [hsv2rgb_pkg::CH_W-1:0]  q_o
);

  localparam int QW    = hsv2rgb_pkg::CH_W;
  // With x below 2^XW, floor(x * floor(2^XW / D) / 2^XW) is at most one short.
  localparam int RECIP = (1 << XW) / DIVISOR;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = XW + RW;

  // Estimate stage.
  logic [PW-1:0] prod;
  logic [XW-1:0] x_q;
  logic [QW-1:0] q0_q;

  assign prod = PW'(x_i) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q  <= x_i;
      q0_q <= prod[XW +: QW];
    end
  end

  // Correction: bump the quotient when the remainder reaches the divisor.
  logic [XW-1:0] rem;

  assign rem = x_q - XW'(q0_q) * XW'(DIVISOR);
  assign q_o = (rem >= XW'(DIVISOR)) ? (q0_q + QW'(1)) : q0_q;

  // The estimate must never be more than one below the true quotient.
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |-> (rem < XW'(2 * DIVISOR)))
    else $error("constant divider estimate is off by more than one");

endmodule

FILE: sv/hsv2rgb_back.sv
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Three pipeline stages: the two products, the divisions by constants, and
// the routing of the three levels to red, green and blue.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hsv2rgb_pkg::front_t          in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hsv2rgb_pkg::CH_W-1:0] red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] blue_o
);

  localparam int CW  = hsv2rgb_pkg::CH_W;
  localparam int BW  = hsv2rgb_pkg::BASE_W;
  localparam int SPW = hsv2rgb_pkg::SMALL_PROD_W;
  localparam int MPW = hsv2rgb_pkg::MID_PROD_W;

  // Stage handshake.
  logic v3_q, v4_q, v5_q;
  logic en3, en4, en5;

  assign en5         = !v5_q || out_ready_i;
  assign en4         = !v4_q || en5;
  assign en3         = !v3_q || en4;
  assign in_ready_o  = en3;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= in_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  // Stage 3: numerators of the low level and the middle level.
  logic [BW-1:0]        base_q;
  logic [SPW-1:0]       small_num_q;
  logic [MPW-1:0]       mid_num_q;
  hsv2rgb_pkg::sector_e sector3_q;
  logic                 black3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      base_q      <= in_i.base;
      small_num_q <= SPW'(in_i.base) * SPW'(in_i.comp_sat);
      mid_num_q   <= MPW'(in_i.base) * MPW'(in_i.k);
      sector3_q   <= in_i.sector;
      black3_q    <= in_i.black;
    end
  end

  // Stage 4: divisions by constants, estimate registered inside each divider.
  hsv2rgb_pkg::stage_ctl_t div_ctl;
  logic [CW-1:0]           big_lvl, small_lvl, mid_lvl;
  hsv2rgb_pkg::sector_e    sector4_q;
  logic                    black4_q;

  assign div_ctl.load  = en4;
  assign div_ctl.valid = v4_q;

  hsv2rgb_cdiv #(
    .XW      (BW),
    .DIVISOR (hsv2rgb_pkg::DIV_BIG)
  ) u_div_big (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .x_i    (base_q),
    .q_o    (big_lvl)
  );

  hsv2rgb_cdiv #(
    .XW      (SPW),
    .DIVISOR (hsv2rgb_pkg::DIV_SMALL)
  ) u_div_small (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .x_i    (small_num_q),
    .q_o    (small_lvl)
  );

  hsv2rgb_cdiv #(
    .XW      (MPW),
    .DIVISOR (hsv2rgb_pkg::DIV_MID)
  ) u_div_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .x_i    (mid_num_q),
    .q_o    (mid_lvl)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sector4_q <= sector3_q;
      black4_q  <= black3_q;
    end
  end

  // Stage 5: route the levels by sector; an out-of-range hue gives black.
  logic [CW-1:0] red_d, green_d, blue_d;
  logic [CW-1:0] red_q, green_q, blue_q;

  always_comb begin
    unique case (sector4_q)
      hsv2rgb_pkg::SECT_RED_YELLOW: begin
        red_d = big_lvl;   green_d = mid_lvl;   blue_d = small_lvl;
      end
      hsv2rgb_pkg::SECT_YELLOW_GREEN: begin
        red_d = mid_lvl;   green_d = big_lvl;   blue_d = small_lvl;
      end
      hsv2rgb_pkg::SECT_GREEN_CYAN: begin
        red_d = small_lvl; green_d = big_lvl;   blue_d = mid_lvl;
      end
      hsv2rgb_pkg::SECT_CYAN_BLUE: begin
        red_d = small_lvl; green_d = mid_lvl;   blue_d = big_lvl;
      end
      hsv2rgb_pkg::SECT_BLUE_MAGENTA: begin
        red_d = mid_lvl;   green_d = small_lvl; blue_d = big_lvl;
      end
      default: begin
        red_d = big_lvl;   green_d = small_lvl; blue_d = mid_lvl;
      end
    endcase
    if (black4_q) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // The three levels are ordered: low <= middle <= high.
  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (big_lvl >= mid_lvl && mid_lvl >= small_lvl))
    else $error("channel levels out of order");

  // A hue out of range reaches the output as black.
  a_black_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5 && black4_q) |=> (red_q == '0 && green_q == '0 && blue_q == '0))
    else $error("out-of-range hue did not give black");

endmodule

FILE: sv/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a stream of HSV pixels into 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on the s_axis channel as hue in degrees with saturation
//   and value in percent, and leaves on the m_axis channel as one RGB pixel.
//   An item moves when tvalid and tready are both high at a rising edge.
//   Saturation and value above 100 count as 100; a hue of 360 or more
//   gives black.
//   The pipeline has five register stages (decode, base and weight,
//   products, reciprocal estimate, correction and channel routing); an
//   item is presented on m_axis_tvalid_o once it reaches the last one.
//   While m_axis_tready_i is high, one item is taken in every cycle.
//   Each stage carries its own valid bit and loads whenever it is empty or
//   its content moves on, so bubbles close up and a stall loses and repeats
//   no item. While the receiver holds m_axis_tready_i low, up to five items
//   are held and s_axis_tready_o drops only once every stage is full.
//   Reset clears all valid bits, so the block accepts items as soon as
//   reset is released.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
  input  logic [hsv2rgb_pkg::TDATA_W-1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hsv2rgb_pkg::TDATA_W-1:0] m_axis_tdata_o
);

  localparam int HW = hsv2rgb_pkg::HUE_W;
  localparam int PW = hsv2rgb_pkg::PCT_W;
  localparam int CW = hsv2rgb_pkg::CH_W;

  logic                 front_valid, front_ready;
  hsv2rgb_pkg::front_t  front_data;
  logic [CW-1:0]        red, green, blue;

  // Clamping, sector decode, base and weight.
  hsv2rgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .hue_i        (s_axis_tdata_i[HW-1:0]),
    .saturation_i (s_axis_tdata_i[HW +: PW]),
    .brightness_i (s_axis_tdata_i[HW + PW +: PW]),
    .out_valid_o  (front_valid),
    .out_ready_i  (front_ready),
    .out_o        (front_data)
  );

  // Products, constant divisions and channel routing.
  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

endmodule
